// ===== src/jfv_pkg.sv =====
package jfv_pkg;

  // Field widths of one incoming word and one result word.
  localparam int ID_W     = 16;
  localparam int SIZE_W   = 16;
  localparam int CNT_W    = 5;
  localparam int VOL_W    = 20;
  localparam int STATUS_W = 2;

  // Default number of job slots.
  localparam int DEPTH_DEFAULT = 16;

  // Operation codes carried by func.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Status codes reported with every result.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One stored job.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } jfv_job_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic push;
    logic pop;
  } jfv_ctrl_t;

endpackage

// ===== src/job_fifo_with_volume.sv =====
// The result word of an accepted input word is registered and appears in the next cycle.
// Throughput: one word per cycle; the output register is refilled in the
// cycle it is taken, so input stalls only while a result waits unread.
// The queue is a row of DEPTH cells that shifts towards the head on a pop.
// Reset clears the cell occupancy, count, running volume and output valid;
// no clearing pass is needed.
module job_fifo_with_volume
  import jfv_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [ID_W-1:0]     job_id,
  input  logic [SIZE_W-1:0]   job_size,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_W-1:0]     popped_id,
  output logic [CNT_W-1:0]    item_count,
  output logic [VOL_W-1:0]    total_volume,
  output logic [SIZE_W-1:0]   head_duration,
  output logic [STATUS_W-1:0] status
);

  localparam int CW = $clog2(DEPTH + 1);

  logic             cell_valid [DEPTH];
  jfv_job_t         cell_job   [DEPTH];
  jfv_ctrl_t        ctrl;
  jfv_job_t         new_job;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    cnt_next;
  logic [CW+4:0]    cnt_wide;
  logic [VOL_W-1:0] vol;
  logic [VOL_W-1:0] vol_next;
  logic [SIZE_W-1:0]   head_next;
  logic [ID_W-1:0]     popped_next;
  logic [STATUS_W-1:0] status_next;
  logic             in_acc;
  logic             empty;
  logic             full;

  // Handshake: a new word is taken whenever the result register is free
  // or is being emptied in this cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign empty    = !cell_valid[0];
  assign full     = cell_valid[DEPTH-1];
  assign new_job  = '{id: job_id, size: job_size};

  // Operation decode; refused operations leave the row untouched.
  assign ctrl.push = in_acc && (func == FUNC_PUSH) && !full;
  assign ctrl.pop  = in_acc && (func == FUNC_POP) && !empty;

  // The row of cells; the head sits in cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic     prev_v;
    logic     nxt_v;
    jfv_job_t nxt_j;
    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nxt_v = 1'b0;
      assign nxt_j = '0;
    end else begin : g_inner
      assign nxt_v = cell_valid[i+1];
      assign nxt_j = cell_job[i+1];
    end
    jfv_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prev_v),
      .nxt_valid  (nxt_v),
      .nxt_job    (nxt_j),
      .new_job    (new_job),
      .valid      (cell_valid[i]),
      .job        (cell_job[i])
    );
  end

  // Result of the current word, worked out from the state before it.
  always_comb begin
    cnt_next    = cnt;
    vol_next    = vol;
    popped_next = '0;
    status_next = ST_DONE;
    head_next   = empty ? '0 : cell_job[0].size;
    if (func == FUNC_PUSH) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        cnt_next = cnt + 1'b1;
        vol_next = vol + {{(VOL_W-SIZE_W){1'b0}}, job_size};
        if (empty) begin
          head_next = job_size;
        end
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        cnt_next    = cnt - 1'b1;
        vol_next    = vol - {{(VOL_W-SIZE_W){1'b0}}, cell_job[0].size};
        popped_next = cell_job[0].id;
        head_next   = cell_valid[1] ? cell_job[1].size : '0;
      end
    end
  end

  // The reported count wraps at the field width.
  assign cnt_wide = {5'b0, cnt_next};

  // Count, running volume and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      vol       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt <= cnt_next;
        vol <= vol_next;
      end
      if (in_acc) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      popped_id     <= popped_next;
      item_count    <= cnt_wide[CNT_W-1:0];
      total_volume  <= vol_next;
      head_duration <= head_next;
      status        <= status_next;
    end
  end

  // The count register agrees with the occupancy of the row.
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) == empty)
    else $error("count and head cell occupancy disagree");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    (cnt == CW'(DEPTH)) == full)
    else $error("count and tail cell occupancy disagree");

  // An empty queue holds no volume.
  a_empty_vol: assert property (@(posedge clk) disable iff (rst)
    empty |-> (vol == '0))
    else $error("volume is not zero on an empty queue");

  // A pop from an empty queue is flagged in the next result.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (func == FUNC_POP) && empty) |=> (status == ST_EMPTY))
    else $error("pop from empty queue not flagged");

endmodule

// ===== src/jfv_cell.sv =====
module jfv_cell
  import jfv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  jfv_ctrl_t ctrl,
  input  logic      prev_valid,
  input  logic      nxt_valid,
  input  jfv_job_t  nxt_job,
  input  jfv_job_t  new_job,
  output logic      valid,
  output jfv_job_t  job
);

  // A push lands in the first empty cell: this one is empty and its
  // neighbour towards the head is occupied.
  logic take_new;
  assign take_new = ctrl.push && !valid && prev_valid;

  // Occupancy: a pop shifts the row one place towards the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= nxt_valid;
    end else if (take_new) begin
      valid <= 1'b1;
    end
  end

  // Job contents follow the same shift or load.
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      job <= nxt_job;
    end else if (take_new) begin
      job <= new_job;
    end
  end

endmodule
